/* hdl/ogi_pkg.sv */
// ----------------------------------------------------------------------------
// ogi_pkg: shared definitions for the occupancy grid inflation core
// Sizes, configuration register indexes and the token carried by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ogi_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 8;

    // Number of line-buffer cells (one per extra row of the vertical window).
    localparam int NUM_TAPS = 2 * MAX_RADIUS;
    // Horizontal window length.
    localparam int HWIN     = 2 * MAX_RADIUS + 1;

    localparam int DIM_W  = 11;
    localparam int RAD_W  = 4;
    localparam int VAL_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SAT_W  = $clog2(HWIN) + 1;
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                   + MAX_RADIUS + 1) + 1;
    localparam int VDEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
    localparam int VADR_W = $clog2(VDEPTH);

    localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

    localparam logic signed [VAL_W-1:0] WALL_VALUE = 8'sd100;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    // Payload handed from cell to cell.
    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic [SAT_W-1:0]        row_sat;
        logic                    wbit;
        logic                    acc;
        logic signed [VAL_W-1:0] value;
        logic                    emit;
        logic                    last;
        logic [SAT_W-1:0]        cl;
        logic [SAT_W-1:0]        cr;
    } t_tok;

endpackage

`default_nettype wire

/* hdl/ogi_cell.sv */
// ----------------------------------------------------------------------------
// ogi_cell: one line-buffer cell of the vertical wall chain
// Delays the wall bit stream by one grid row and folds the delayed bit into
// the running vertical OR carried by the word.
// ----------------------------------------------------------------------------
`default_nettype none

module ogi_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire [ogi_pkg::SAT_W-1:0] i_tap,
    input  wire [ogi_pkg::SAT_W-1:0] i_two_r,
    input  wire                     i_valid,
    input  ogi_pkg::t_tok           i_tok,
    output logic                    o_valid,
    output ogi_pkg::t_tok           o_tok
);

    logic                 r_valid;
    ogi_pkg::t_tok        r_tok;
    logic                 r_rd;
    logic                 r_incl;
    logic                 r_mem [ogi_pkg::MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok  <= i_tok;
            r_rd   <= r_mem[i_tok.col];
            r_incl <= (i_tap <= i_two_r) && (i_tok.row_sat >= i_tap);
            if (i_valid) begin
                r_mem[i_tok.col] <= i_tok.wbit;
            end
        end
    end

    always_comb begin
        o_tok      = r_tok;
        o_tok.wbit = r_rd;
        o_tok.acc  = r_tok.acc | (r_rd & r_incl);
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hdl/ogi_window.sv */
// ----------------------------------------------------------------------------
// ogi_window: horizontal window and output register
// Shifts the column ORs through a row of cells, clips the window at the row
// edges and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ogi_window (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire [ogi_pkg::SAT_W-1:0] i_r,
    input  wire [ogi_pkg::SAT_W-1:0] i_two_r,
    input  wire                      i_valid,
    input  ogi_pkg::t_tok            i_tok,
    output logic                     o_valid,
    output logic [ogi_pkg::VAL_W-1:0] o_value,
    output logic                     o_last
);

    logic [ogi_pkg::HWIN-2:0] r_h;
    logic [ogi_pkg::HWIN-1:0] n_h;
    logic [ogi_pkg::HWIN-1:0] incl;
    logic                     hit;
    logic                     r_valid;
    logic [ogi_pkg::VAL_W-1:0] r_value;
    logic                     r_last;

    assign n_h = {r_h, i_tok.acc};

    // Cell i holds the column i places left of the newest one; the center sits
    // at cell r. A column is used only when it lies in the center's row.
    always_comb begin
        for (int i = 0; i < ogi_pkg::HWIN; i++) begin
            if (ogi_pkg::SAT_W'(i) > i_two_r) begin
                incl[i] = 1'b0;
            end else if (ogi_pkg::SAT_W'(i) >= i_r) begin
                incl[i] = (ogi_pkg::SAT_W'(i) - i_r) <= i_tok.cl;
            end else begin
                incl[i] = (i_r - ogi_pkg::SAT_W'(i)) <= i_tok.cr;
            end
        end
        hit = |(n_h & incl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && i_tok.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_h     <= n_h[ogi_pkg::HWIN-2:0];
            r_value <= hit ? ogi_pkg::WALL_VALUE : i_tok.value;
            r_last  <= i_tok.last;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

`default_nettype wire

/* hdl/occupancy_grid_inflation_core.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_inflation_core: square-window wall inflation of a grid
// Cells arrive on the slave stream in raster order; each output cell becomes
// 100 when a wall (value 100) lies within the configured radius of it.
//
// Usage:
// - Input words: tdata is the signed cell value, tuser bit 0 marks the first
//   cell of a grid, tuser bit 1 marks a filler word.
// - Output cell k leaves after input word k + radius*width + radius has been
//   taken; the host appends that many filler words to drain a grid. tlast
//   marks the final cell of the grid.
// - One word per cycle is taken while the master side does not stall. A word
//   accepted at an edge enters the first line-buffer cell, passes through the
//   other cells in order and then the window stage into the output register.
// - When the master side stalls the whole chain holds; input is taken only
//   when the output register is empty or being read in the same cycle.
// - Configuration writes (width, height, radius) are accepted every cycle and
//   are meant to happen between grids. Width, height and radius[3:0] saturate.
// - Reset clears the counters and sets width and height to 1024, radius to 0.
//   The line buffers and the value delay memory are not cleared; reads of
//   rows above the grid are masked off.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_inflation_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [10:0] i_cfg_data,
    // Slave stream.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,  // [7:0] cell_value
    input  wire  [1:0]  i_s_axis_tuser,  // [0] frame_start, [1] padding
    // Master stream.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] out_value
    output logic        o_m_axis_tlast
);

    localparam int SAT_W = ogi_pkg::SAT_W;
    localparam int POS_W = ogi_pkg::POS_W;
    localparam int DIM_W = ogi_pkg::DIM_W;
    localparam int COL_W = ogi_pkg::COL_W;
    localparam int VADR_W = ogi_pkg::VADR_W;

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] r_w, r_h;
    logic [ogi_pkg::RAD_W-1:0] r_r;
    logic [POS_W-1:0] r_n, r_d, r_nd;
    logic [DIM_W-1:0] cand_w, cand_h, clamp_dim;
    logic [ogi_pkg::RAD_W-1:0] cand_r, clamp_r;
    logic [POS_W-1:0] n_n, n_d;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            clamp_dim = DIM_W'(1);
        end else if (i_cfg_data > DIM_W'(ogi_pkg::MAX_WIDTH)) begin
            clamp_dim = DIM_W'(ogi_pkg::MAX_WIDTH);
        end else begin
            clamp_dim = i_cfg_data;
        end
        if (i_cfg_data[3:0] > ogi_pkg::RAD_W'(ogi_pkg::MAX_RADIUS)) begin
            clamp_r = ogi_pkg::RAD_W'(ogi_pkg::MAX_RADIUS);
        end else begin
            clamp_r = i_cfg_data[3:0];
        end
        cand_w = r_w;
        cand_h = r_h;
        cand_r = r_r;
        case (i_cfg_addr)
            ogi_pkg::CFG_WIDTH:  cand_w = clamp_dim;
            ogi_pkg::CFG_HEIGHT: begin
                if (i_cfg_data > DIM_W'(ogi_pkg::MAX_HEIGHT)) begin
                    cand_h = DIM_W'(ogi_pkg::MAX_HEIGHT);
                end else if (i_cfg_data == '0) begin
                    cand_h = DIM_W'(1);
                end else begin
                    cand_h = i_cfg_data;
                end
            end
            ogi_pkg::CFG_RADIUS: cand_r = clamp_r;
            default: ;
        endcase
        n_n = POS_W'(cand_w) * POS_W'(cand_h);
        n_d = POS_W'(cand_r) * POS_W'(cand_w) + POS_W'(cand_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= DIM_W'(ogi_pkg::MAX_WIDTH);
            r_h  <= DIM_W'(ogi_pkg::MAX_HEIGHT);
            r_r  <= '0;
            r_n  <= POS_W'(ogi_pkg::MAX_WIDTH * ogi_pkg::MAX_HEIGHT);
            r_d  <= '0;
            r_nd <= POS_W'(ogi_pkg::MAX_WIDTH * ogi_pkg::MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            r_w  <= cand_w;
            r_h  <= cand_h;
            r_r  <= cand_r;
            r_n  <= n_n;
            r_d  <= n_d;
            r_nd <= n_n + n_d;
        end
    end

    logic [SAT_W-1:0] rad, two_r;
    assign rad   = SAT_W'(r_r);
    assign two_r = SAT_W'({r_r, 1'b0});

    // ---------------- input stage ----------------
    logic en, accept, fs, pad;
    logic win_valid;

    assign en              = !win_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;
    assign fs              = i_s_axis_tuser[0];
    assign pad             = i_s_axis_tuser[1];

    logic [POS_W-1:0]  r_a, a_e;
    logic [COL_W-1:0]  r_col, col_e;
    logic [SAT_W-1:0]  r_row, row_e;
    logic [DIM_W-1:0]  r_kcol, kcol_e, right;
    logic [VADR_W-1:0] r_wp, wp_e, rp;
    logic in_grid, active, emit, last;
    logic signed [ogi_pkg::VAL_W-1:0] v_in;
    ogi_pkg::t_tok head;

    always_comb begin
        a_e     = fs ? '0 : r_a;
        col_e   = fs ? '0 : r_col;
        row_e   = fs ? '0 : r_row;
        kcol_e  = fs ? '0 : r_kcol;
        wp_e    = fs ? '0 : r_wp;
        in_grid = a_e < r_n;
        active  = a_e < r_nd;
        emit    = active && (a_e >= r_d);
        last    = a_e == (r_nd - POS_W'(1));
        v_in    = pad ? '0 : i_s_axis_tdata;
        right   = r_w - DIM_W'(1) - kcol_e;
        if (wp_e >= VADR_W'(r_d)) begin
            rp = wp_e - VADR_W'(r_d);
        end else begin
            rp = VADR_W'(POS_W'(wp_e) + POS_W'(ogi_pkg::VDEPTH) - r_d);
        end

        head.col     = col_e;
        head.row_sat = row_e;
        head.wbit    = in_grid && (v_in == ogi_pkg::WALL_VALUE);
        head.acc     = head.wbit;
        head.value   = '0;
        head.emit    = emit;
        head.last    = last;
        head.cl      = (kcol_e > DIM_W'(ogi_pkg::SAT_MAX)) ? ogi_pkg::SAT_MAX
                                                          : SAT_W'(kcol_e);
        head.cr      = (right > DIM_W'(ogi_pkg::SAT_MAX)) ? ogi_pkg::SAT_MAX
                                                         : SAT_W'(right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_kcol <= '0;
            r_wp   <= '0;
        end else if (accept) begin
            r_a    <= a_e;
            r_col  <= col_e;
            r_row  <= row_e;
            r_kcol <= kcol_e;
            r_wp   <= wp_e;
            if (active) begin
                r_a <= a_e + POS_W'(1);
                if (DIM_W'(col_e) == r_w - DIM_W'(1)) begin
                    r_col <= '0;
                    if (row_e != ogi_pkg::SAT_MAX) begin
                        r_row <= row_e + SAT_W'(1);
                    end
                end else begin
                    r_col <= col_e + COL_W'(1);
                end
                if (wp_e == VADR_W'(ogi_pkg::VDEPTH - 1)) begin
                    r_wp <= '0;
                end else begin
                    r_wp <= wp_e + VADR_W'(1);
                end
                if (emit) begin
                    r_kcol <= (kcol_e == r_w - DIM_W'(1)) ? '0 : kcol_e + DIM_W'(1);
                end
            end
        end
    end

    // ---------------- value delay memory ----------------
    logic signed [ogi_pkg::VAL_W-1:0] r_vmem [ogi_pkg::VDEPTH];
    logic signed [ogi_pkg::VAL_W-1:0] r_vrd, r_vin;
    logic r_byp;

    always_ff @(posedge i_clk) begin
        if (accept && in_grid) begin
            r_vmem[wp_e] <= v_in;
        end
        if (en) begin
            r_vrd <= r_vmem[rp];
            r_vin <= v_in;
            r_byp <= r_d == '0;
        end
    end

    // ---------------- chain of line-buffer cells ----------------
    ogi_pkg::t_tok link  [ogi_pkg::NUM_TAPS+1];
    ogi_pkg::t_tok raw   [ogi_pkg::NUM_TAPS];
    logic          lval  [ogi_pkg::NUM_TAPS+1];

    assign link[0] = head;
    assign lval[0] = accept;

    for (genvar g = 0; g < ogi_pkg::NUM_TAPS; g++) begin : g_cell
        ogi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tap   (SAT_W'(g + 1)),
            .i_two_r (two_r),
            .i_valid (lval[g]),
            .i_tok   (link[g]),
            .o_valid (lval[g+1]),
            .o_tok   (raw[g])
        );
        if (g == 0) begin : g_fix
            // The delayed cell value joins the word after the first cell.
            always_comb begin
                link[1]       = raw[0];
                link[1].value = r_byp ? r_vin : r_vrd;
            end
        end else begin : g_pass
            assign link[g+1] = raw[g];
        end
    end

    // ---------------- window and output ----------------
    logic [ogi_pkg::VAL_W-1:0] win_value;
    logic win_last;

    ogi_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_r     (rad),
        .i_two_r (two_r),
        .i_valid (lval[ogi_pkg::NUM_TAPS]),
        .i_tok   (link[ogi_pkg::NUM_TAPS]),
        .o_valid (win_valid),
        .o_value (win_value),
        .o_last  (win_last)
    );

    assign o_m_axis_tvalid = win_valid;
    assign o_m_axis_tdata  = win_value;
    assign o_m_axis_tlast  = win_last;

    // ---------------- assertions ----------------
    a_fs_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && fs && !i_cfg_valid) |=> (r_a == POS_W'(1)))
        else $error("frame start did not restart the position counter");

    a_drain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !active) |=> (r_a == $past(r_a)))
        else $error("position counter moved after the grid was drained");

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d < r_nd)
        else $error("output delay not below the frame length");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> (lval[ogi_pkg::NUM_TAPS] == $past(lval[ogi_pkg::NUM_TAPS])))
        else $error("cell chain moved while the output was stalled");

endmodule

`default_nettype wire
